@@ hw/rtl/adh_pkg.sv @@
package adh_pkg;

  // Item kinds carried on s_tuser
  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_ADD_ZERO = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;

  // Register map (index into the register list)
  localparam logic REG_MAX_DEPTH = 1'b0;

  localparam logic [3:0] MAX_DEPTH_RESET = 4'd15;

  // Four 4-bit base counts, A in [0] .. T in [3]
  typedef logic [3:0][3:0] base_counts_t;

  typedef struct packed {
    logic [5:0] total_depth;
    logic [1:0] major_base;
    logic [3:0] major_depth;
    logic [1:0] minor_base;
    logic [3:0] minor_depth;
  } site_stats_t;

endpackage

@@ hw/rtl/adh_stats.sv @@
module adh_stats (
  input  adh_pkg::base_counts_t counts,
  output adh_pkg::site_stats_t  stats
);
  import adh_pkg::*;

  logic [3:0] mx;
  logic [3:0] sec;
  logic [2:0] ties;
  logic [1:0] first;
  logic [1:0] second_tie;
  logic [1:0] minor;
  logic       found;

  always_comb begin
    mx = counts[0];
    for (int i = 1; i < 4; i++) begin
      if (counts[i] > mx) mx = counts[i];
    end

    ties       = 3'd0;
    first      = 2'd0;
    second_tie = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (counts[i] == mx) begin
        if (ties == 3'd0) first = 2'(i);
        else if (ties == 3'd1) second_tie = 2'(i);
        ties = ties + 3'd1;
      end
    end

    // largest count strictly below the maximum
    sec = 4'd0;
    for (int i = 0; i < 4; i++) begin
      if (counts[i] < mx && counts[i] > sec) sec = counts[i];
    end

    minor = 2'd3;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && counts[i] == sec) begin
        minor = 2'(i);
        found = 1'b1;
      end
    end

    stats.total_depth = 6'(counts[0]) + 6'(counts[1]) + 6'(counts[2]) + 6'(counts[3]);
    stats.major_base  = first;
    stats.major_depth = mx;
    if (ties > 3'd1) begin
      stats.minor_base  = second_tie;
      stats.minor_depth = 4'd0;
    end else begin
      stats.minor_base  = minor;
      stats.minor_depth = counts[minor];
    end
  end

endmodule

@@ hw/rtl/allele_depth_histogram.sv @@
// A read transaction passes stage 1 and the output register before its result rises on m_tvalid.
// Throughput: one transaction per cycle outside the clearing pass; a read stalls input
// only while the output register is full and m_tready is low.
// The bin store is one memory, read at acceptance and written back in the following cycle.
// Reset (rst, synchronous) starts a clearing pass over all (MAX_COUNT+1)**4 bins
// (65536 at defaults), one bin per cycle, during which s_tready stays low.
module allele_depth_histogram #(
  parameter int MAX_COUNT   = 15,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // count_a[3:0], count_c[7:4], count_g[11:8], count_t[15:12]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // bin_count[31:0], total_depth[37:32], major_base[39:38],
                                 // major_depth[43:40], minor_base[45:44],
                                 // minor_depth[49:46], zero pad[55:50]
);
  import adh_pkg::*;

  localparam int SIDE = MAX_COUNT + 1;
  localparam int BINS = SIDE * SIDE * SIDE * SIDE;
  localparam int IW   = $clog2(BINS);
  localparam logic [IW-1:0] SIDE_I   = IW'(SIDE);
  localparam logic [IW-1:0] LAST_BIN = IW'(BINS - 1);
  localparam logic [4:0]    MAX_C5   = 5'(MAX_COUNT);

  typedef enum logic [1:0] {OP_NOP, OP_ADD, OP_READ} op_t;

  // bin store
  logic [COUNT_WIDTH-1:0] mem [BINS];
  logic [COUNT_WIDTH-1:0] rdata;

  // control
  logic          clearing;
  logic [IW-1:0] clr_addr;
  logic [3:0]    max_depth;

  // stage 1: item whose bin is being read back
  logic             s1_valid;
  op_t              s1_op;
  logic [IW-1:0]    s1_idx;
  logic             s1_outside;
  base_counts_t     s1_counts;
  logic             s1_fwd;
  logic [COUNT_WIDTH-1:0] fwd_data;

  // output register
  logic        out_valid;
  logic [55:0] out_data;

  // accept-side decode
  base_counts_t  in_counts;
  logic [4:0]    lim;
  logic          in_range;
  logic          in_inside;
  logic [IW-1:0] in_idx;
  op_t           acc_op;
  logic [IW-1:0] acc_idx;
  logic          acc;

  // stage-1 datapath
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;
  logic [63:0]            cur_ext;
  logic [31:0]            cnt32;
  logic                   stall;
  logic                   load;
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                   cfg_we;
  site_stats_t            stats;

  assign in_counts = s_tdata;

  always_comb begin
    lim = (5'(max_depth) > MAX_C5) ? MAX_C5 : 5'(max_depth);
    in_range  = 1'b1;
    in_inside = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (5'(in_counts[i]) > lim)    in_range  = 1'b0;
      if (5'(in_counts[i]) > MAX_C5) in_inside = 1'b0;
    end
    in_idx = ((IW'(in_counts[0]) * SIDE_I + IW'(in_counts[1])) * SIDE_I
              + IW'(in_counts[2])) * SIDE_I + IW'(in_counts[3]);

    case (s_tuser)
      KIND_ADD: begin
        acc_op  = in_range ? OP_ADD : OP_NOP;
        acc_idx = in_range ? in_idx : '0;
      end
      KIND_ADD_ZERO: begin
        acc_op  = OP_ADD;
        acc_idx = '0;
      end
      KIND_READ: begin
        acc_op  = OP_READ;
        acc_idx = in_inside ? in_idx : '0;
      end
      default: begin
        acc_op  = OP_NOP;
        acc_idx = '0;
      end
    endcase
  end

  // a pending read result blocks stage 1 only while the output slot is full and m_tready is low
  assign stall    = s1_valid && s1_op == OP_READ && out_valid && !m_tready;
  assign load     = s1_valid && s1_op == OP_READ && !stall;
  assign s_tready = !clearing && !stall;
  assign acc      = s_tvalid && s_tready;

  // back-to-back add to the same bin: take the value the previous add wrote, not the stale read
  assign cur     = s1_fwd ? fwd_data : rdata;
  assign inc     = (&cur) ? cur : cur + COUNT_WIDTH'(1);
  assign cur_ext = 64'(cur);
  assign cnt32   = s1_outside ? 32'd0 : ((|cur_ext[63:32]) ? 32'hFFFF_FFFF : cur_ext[31:0]);

  assign mem_we    = clearing || (s1_valid && s1_op == OP_ADD);
  assign mem_waddr = clearing ? clr_addr : s1_idx;
  assign mem_wdata = clearing ? '0 : inc;

  adh_stats u_stats (
    .counts (s1_counts),
    .stats  (stats)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (acc) rdata <= mem[acc_idx];
  end

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DEPTH);
  assign prdata = (paddr[2] == REG_MAX_DEPTH) ? {28'd0, max_depth} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      max_depth <= MAX_DEPTH_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == LAST_BIN) clearing <= 1'b0;
        clr_addr <= clr_addr + IW'(1);
      end
      if (cfg_we) max_depth <= pwdata[3:0];
      if (acc) s1_valid <= 1'b1;
      else if (!stall) s1_valid <= 1'b0;
      if (load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op      <= acc_op;
      s1_idx     <= acc_idx;
      s1_outside <= !in_inside;
      s1_counts  <= in_counts;
      s1_fwd     <= s1_valid && s1_op == OP_ADD && s1_idx == acc_idx;
      fwd_data   <= inc;
    end
    if (load) begin
      out_data <= {6'd0, stats.minor_depth, stats.minor_base, stats.major_depth,
                   stats.major_base, stats.total_depth, cnt32};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

@@ hw/rtl/adh_checker.sv @@
module adh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // reset starts the clearing pass and empties the output
  a_reset_quiet: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("input open or result pending right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_minor_le_major: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[49:46] <= m_tdata[43:40] && m_tdata[45:44] != m_tdata[39:38])
    else $error("minor exceeds major or equals major base");

  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 6'(m_tdata[43:40]) + 6'(m_tdata[49:46]) <= m_tdata[37:32]
                 && m_tdata[55:50] == 6'd0)
    else $error("total depth below major plus minor, or pad bits set");

endmodule

bind allele_depth_histogram adh_checker u_adh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
